FILE: rtl/cursor_linked_list_engine_unit_assert.svh
// Assertion macros used by the top RTL file of the linked list engine.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CURSOR_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH
`define CURSOR_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH

// The condition in the same cycle implies the property.
`define CLL_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The condition implies the property in the next cycle.
`define CLL_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: rtl/cll_pkg.sv
package cll_pkg;

    localparam int CELLS     = 16;
    localparam int HEAD_CELL = 1;

    localparam int IDX_W   = 4;
    localparam int POS_W   = 4;
    localparam int VAL_W   = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int STEP_W  = $clog2(CELLS + 1);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_POS   = 2'd3;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] data;
    } link_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [VAL_W-1:0] data;
    } value_wr_t;

    // A link that points outside the cell array counts as the end of a chain.
    function automatic logic [IDX_W-1:0] cell_of(input logic [IDX_W-1:0] x);
        logic [IDX_W:0] limit;
        limit = (IDX_W + 1)'(CELLS);
        return ({1'b0, x} < limit) ? x : '0;
    endfunction

    // Link contents after reset: free chain 0 -> 2 -> 3 -> ... -> CELLS-1,
    // header and last cell end their chains.
    function automatic logic [IDX_W-1:0] link_init(input int unsigned i);
        logic [IDX_W-1:0] r;
        r = '0;
        if (i == 0)
        begin
            r = (CELLS > 2) ? IDX_W'(2) : '0;
        end
        else if (i >= 2 && i + 1 < CELLS && i != HEAD_CELL)
        begin
            r = IDX_W'(i + 1);
        end
        return r;
    endfunction

endpackage

FILE: rtl/cll_store.sv
module cll_store
    import cll_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [IDX_W-1:0] link_rd,
    output logic [VAL_W-1:0] value_rd,
    input  link_wr_t         link_wr,
    input  value_wr_t        value_wr
);

    logic [IDX_W-1:0] link_reg  [CELLS];
    logic [VAL_W-1:0] value_reg [CELLS];

    // Links come out of reset as the initial free chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                link_reg[i] <= link_init(i);
            end
        end
        else if (link_wr.en)
        begin
            link_reg[link_wr.addr] <= link_wr.data;
        end
    end

    // Values carry no reset; a cell is always written before it joins the list.
    always_ff @(posedge clk)
    begin
        if (value_wr.en)
        begin
            value_reg[value_wr.addr] <= value_wr.data;
        end
    end

    assign link_rd  = link_reg[rd_addr];
    assign value_rd = value_reg[rd_addr];

endmodule

FILE: rtl/cursor_linked_list_engine_unit.sv
// Linked list engine: a singly linked list of 32-bit values kept in a fixed
// array of CELLS cells, where cell 0 heads the free list and cell 1 is the list
// header. Each input item is a command: insert a value after a given cell,
// delete the first cell holding a value, or find a value. Each command yields
// exactly one result item carrying a status (ok, not found, store full or bad
// position), the cell that was allocated, freed or found (0 when none), and a
// flag that is high when the list is empty after the command. The block works
// on one item at a time and drops s_tready from acceptance until the result is
// handed to the output register. A successful insert passes through the
// dispatch state, the insert states A, B and C and the final state, while an
// insert rejected for its position or a full store, and an unused command, go
// from dispatch straight to the final state. A find or delete walks the list
// one cell per cycle through the single read port of the cell store. A result
// waiting in the output register does not block the acceptance of the next
// item. The list walk gives up after CELLS cells, so a corrupted chain still
// ends in a not found result.
`include "cursor_linked_list_engine_unit_assert.svh"

module cursor_linked_list_engine_unit
    import cll_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cmd[1:0], value[33:2], position[37:34], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // status[1:0], cell_index[5:2], list_empty[6], zero pad
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_INS_A    = 4'd2;
    localparam logic [3:0] S_INS_B    = 4'd3;
    localparam logic [3:0] S_INS_C    = 4'd4;
    localparam logic [3:0] S_WALK     = 4'd5;
    localparam logic [3:0] S_DEL_A    = 4'd6;
    localparam logic [3:0] S_DEL_B    = 4'd7;
    localparam logic [3:0] S_DEL_C    = 4'd8;
    localparam logic [3:0] S_FIN      = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [VAL_W-1:0]  value_reg, value_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  tgt_reg, tgt_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  before_reg, before_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              empty_reg, empty_next;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] link_rd;
    logic [VAL_W-1:0] value_rd;
    link_wr_t         link_wr;
    value_wr_t        value_wr;
    logic             value_hit;
    logic             slot_free;
    logic [IDX_W-1:0] fresh;

    cll_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .link_rd  (link_rd),
        .value_rd (value_rd),
        .link_wr  (link_wr),
        .value_wr (value_wr)
    );

    // The one compare unit, reused for every cell visited by the walk.
    assign value_hit = (value_rd == value_reg);
    assign fresh     = cell_of(link_rd);
    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        pos_next        = pos_reg;
        tgt_next        = tgt_reg;
        cur_next        = cur_reg;
        before_next     = before_reg;
        steps_next      = steps_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        idx_next        = idx_reg;
        empty_next      = empty_reg;
        rd_addr         = '0;
        link_wr         = '0;
        value_wr        = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tdata[1:0];
                    value_next = s_tdata[33:2];
                    pos_next   = s_tdata[37:34];
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        rd_addr = '0;
                        if (pos_reg == '0 || {1'b0, pos_reg} >= (POS_W + 1)'(CELLS))
                        begin
                            res_status_next = ST_BAD_POS;
                            res_idx_next    = '0;
                            state_next      = S_FIN;
                        end
                        else if (fresh == '0)
                        begin
                            res_status_next = ST_FULL;
                            res_idx_next    = '0;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            tgt_next   = fresh;
                            state_next = S_INS_A;
                        end
                    end
                    CMD_DELETE, CMD_FIND:
                    begin
                        rd_addr     = IDX_W'(HEAD_CELL);
                        cur_next    = fresh;
                        before_next = IDX_W'(HEAD_CELL);
                        steps_next  = '0;
                        state_next  = S_WALK;
                    end
                    default:
                    begin
                        res_status_next = ST_BAD_POS;
                        res_idx_next    = '0;
                        state_next      = S_FIN;
                    end
                endcase
            end
            S_INS_A:
            begin
                // Unlink the fresh cell from the free list.
                rd_addr      = tgt_reg;
                link_wr.en   = 1'b1;
                link_wr.addr = '0;
                link_wr.data = fresh;
                state_next   = S_INS_B;
            end
            S_INS_B:
            begin
                // The fresh cell takes the value and the successor of the position.
                rd_addr       = IDX_W'(pos_reg);
                link_wr.en    = 1'b1;
                link_wr.addr  = tgt_reg;
                link_wr.data  = fresh;
                value_wr.en   = 1'b1;
                value_wr.addr = tgt_reg;
                value_wr.data = value_reg;
                state_next    = S_INS_C;
            end
            S_INS_C:
            begin
                link_wr.en      = 1'b1;
                link_wr.addr    = IDX_W'(pos_reg);
                link_wr.data    = tgt_reg;
                res_status_next = ST_OK;
                res_idx_next    = tgt_reg;
                state_next      = S_FIN;
            end
            S_WALK:
            begin
                rd_addr = cur_reg;
                priority if (cur_reg == '0 || steps_reg == STEP_W'(CELLS))
                begin
                    res_status_next = ST_NOT_FOUND;
                    res_idx_next    = '0;
                    state_next      = S_FIN;
                end
                else if (value_hit)
                begin
                    tgt_next = cur_reg;
                    if (cmd_reg == CMD_FIND)
                    begin
                        res_status_next = ST_OK;
                        res_idx_next    = cur_reg;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_DEL_A;
                    end
                end
                else
                begin
                    before_next = cur_reg;
                    cur_next    = fresh;
                    steps_next  = steps_reg + 1'b1;
                end
            end
            S_DEL_A:
            begin
                // Bridge the predecessor over the target.
                rd_addr      = tgt_reg;
                link_wr.en   = 1'b1;
                link_wr.addr = before_reg;
                link_wr.data = fresh;
                state_next   = S_DEL_B;
            end
            S_DEL_B:
            begin
                // The target points at the old front of the free list.
                rd_addr      = '0;
                link_wr.en   = 1'b1;
                link_wr.addr = tgt_reg;
                link_wr.data = fresh;
                state_next   = S_DEL_C;
            end
            S_DEL_C:
            begin
                link_wr.en      = 1'b1;
                link_wr.addr    = '0;
                link_wr.data    = tgt_reg;
                res_status_next = ST_OK;
                res_idx_next    = tgt_reg;
                state_next      = S_FIN;
            end
            S_FIN:
            begin
                // The header's link gives the empty flag once all writes have landed.
                rd_addr = IDX_W'(HEAD_CELL);
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    idx_next       = res_idx_reg;
                    empty_next     = (link_rd == '0);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        value_reg      <= value_next;
        pos_reg        <= pos_next;
        tgt_reg        <= tgt_next;
        cur_reg        <= cur_next;
        before_reg     <= before_next;
        steps_reg      <= steps_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        status_reg     <= status_next;
        idx_reg        <= idx_next;
        empty_reg      <= empty_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, empty_reg, idx_reg, status_reg};

    // A new result only appears from the final state.
    `CLL_ASSERT_NXT(a_result_from_fin, !out_valid_reg && state_reg != S_FIN, !out_valid_reg, "result appeared outside the final state")
    // A successful command always names a real cell.
    `CLL_ASSERT_IMP(a_ok_has_cell, out_valid_reg && status_reg == ST_OK, idx_reg != '0, "ok result without a cell")
    // Failures never name a cell.
    `CLL_ASSERT_IMP(a_fail_no_cell, out_valid_reg && status_reg != ST_OK, idx_reg == '0, "failed result names a cell")
    // The walk is bounded by the cell count.
    `CLL_ASSERT_IMP(a_walk_bound, state_reg == S_WALK, steps_reg <= STEP_W'(CELLS), "list walk overran its bound")
    // On delete the predecessor is never the free list head and never the target itself.
    `CLL_ASSERT_IMP(a_before_valid, state_reg == S_DEL_A, before_reg != '0 && tgt_reg != before_reg, "bad predecessor on delete")

endmodule
